// ===== rtl/pcot_pkg.sv =====
// ----------------------------------------------------------------------------
// pcot_pkg
// Shared types, constants and lookup tables for the pixel color transform.
// The per-channel curves are built into constant tables at elaboration.
// ----------------------------------------------------------------------------
package pcot_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LUT_DEPTH = 1 << BYTE_W;

   localparam longint unsigned ONE_Q = 64'd65536;
   localparam longint unsigned HALF_Q = 64'd32768;
   localparam longint unsigned FIFTH_Q = 64'd13107;
   localparam longint unsigned FOUR_FIFTHS_Q = 64'd52428;
   localparam longint unsigned QUARTER_Q = 64'd16384;
   localparam longint unsigned THREE_QUARTERS_Q = 64'd49152;
   localparam longint unsigned BYTE_MAX = 64'd255;

   // Smallest blue bytes whose normalized value reaches 0.25 and 0.75
   localparam logic [BYTE_W-1:0] BLUE_QUARTER_BYTE =
      BYTE_W'((QUARTER_Q * BYTE_MAX + ONE_Q - 1) / ONE_Q);
   localparam logic [BYTE_W-1:0] BLUE_THREE_QUARTERS_BYTE =
      BYTE_W'((THREE_QUARTERS_Q * BYTE_MAX + ONE_Q - 1) / ONE_Q);

   localparam logic [BYTE_W-1:0] WHITE_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      FACTOR_NONE,
      FACTOR_FIFTH,
      FACTOR_HALF,
      FACTOR_FOUR_FIFTHS
   } factor_type;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef logic [BYTE_W-1:0] lut_type [LUT_DEPTH];

   // Sideband that travels beside the lanes
   typedef struct packed {
      logic [BYTE_W-1:0] alpha;
      logic              end_of_image;
      logic              force_white;
   } side_type;

   // Blend factor in Q1.16
   function automatic longint unsigned factor_q(input factor_type f);
      longint unsigned v;
      v = 0;
      case (f)
         FACTOR_FIFTH:       v = FIFTH_Q;
         FACTOR_HALF:        v = HALF_Q;
         FACTOR_FOUR_FIFTHS: v = FOUR_FIFTHS_Q;
         default:            v = 0;
      endcase
      return v;
   endfunction

   // Restoring shift-subtract quotient, elaboration only
   function automatic longint unsigned q_quot(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned rem;
      longint unsigned quo;
      rem = 0;
      quo = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 1) | ((num >> i) & 64'd1);
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // Digit-by-digit integer square root, elaboration only
   function automatic longint unsigned q_sqrt(input longint unsigned n_in);
      longint unsigned n;
      longint unsigned res;
      longint unsigned bitv;
      n = n_in;
      res = 0;
      bitv = 64'd1 << 40;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Decoded Q1.16 value of a channel byte, before the blend is undone
   function automatic longint unsigned dec_value(input longint unsigned byte_v);
      longint unsigned c;
      longint unsigned q;
      c = (byte_v * ONE_Q) / BYTE_MAX;
      if (c > ONE_Q) c = ONE_Q;
      q = q_quot((ONE_Q - c) << 16, ONE_Q + c);
      return q_sqrt(q << 16);
   endfunction

   // Largest byte whose decoded value still reaches a threshold; the curve falls
   function automatic logic [BYTE_W-1:0] dec_last_byte(input longint unsigned th);
      logic [BYTE_W-1:0] last;
      last = '0;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         if (dec_value(longint'(i)) >= th) last = BYTE_W'(i);
      end
      return last;
   endfunction

   // Largest blue bytes whose decoded value reaches 0.25 and 0.75
   localparam logic [BYTE_W-1:0] BLUE_DEC_QUARTER_BYTE = dec_last_byte(QUARTER_Q);
   localparam logic [BYTE_W-1:0] BLUE_DEC_THREE_QUARTERS_BYTE =
      dec_last_byte(THREE_QUARTERS_Q);

   function automatic longint unsigned q_to_byte(input longint unsigned v_in);
      longint unsigned v;
      v = (v_in > ONE_Q) ? ONE_Q : v_in;
      return (v * BYTE_MAX) >> 16;
   endfunction

   // Build one channel curve for a mode and blend factor
   function automatic lut_type build_lut(input mode_type m, input factor_type f);
      lut_type         t;
      longint unsigned a;
      longint unsigned s;
      longint unsigned fq;
      fq = factor_q(f);
      for (int i = 0; i < LUT_DEPTH; i++) begin
         a = (longint'(i) * ONE_Q) / BYTE_MAX;
         if (m == MODE_ENCODE) begin
            if (f != FACTOR_NONE && a >= HALF_Q) begin
               a = ((a * (ONE_Q - fq)) >> 16) + (fq >> 1);
            end
            s = (a * a) >> 16;
            if (s > ONE_Q) s = ONE_Q;
            a = q_quot((ONE_Q - s) << 16, ONE_Q + s);
         end else begin
            if (a > ONE_Q) a = ONE_Q;
            s = q_quot((ONE_Q - a) << 16, ONE_Q + a);
            a = q_sqrt(s << 16);
            if (f != FACTOR_NONE && a >= HALF_Q) begin
               a = q_quot((a - (fq >> 1)) << 16, ONE_Q - fq);
               if (a > ONE_Q) a = ONE_Q;
            end
         end
         t[i] = BYTE_W'(q_to_byte(a));
      end
      return t;
   endfunction

endpackage

// ===== rtl/pcot_lane.sv =====
// ----------------------------------------------------------------------------
// pcot_lane
// One color channel: looks up the curve for the mode and blend factor.
// ----------------------------------------------------------------------------
module pcot_lane
   import pcot_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  mode_type          mode,
   input  factor_type        factor,
   input  logic [BYTE_W-1:0] byte_in,
   output logic [BYTE_W-1:0] byte_out
);

   localparam lut_type ENC_NONE = build_lut(MODE_ENCODE, FACTOR_NONE);
   localparam lut_type ENC_FIFTH = build_lut(MODE_ENCODE, FACTOR_FIFTH);
   localparam lut_type ENC_HALF = build_lut(MODE_ENCODE, FACTOR_HALF);
   localparam lut_type ENC_FOUR = build_lut(MODE_ENCODE, FACTOR_FOUR_FIFTHS);
   localparam lut_type DEC_NONE = build_lut(MODE_DECODE, FACTOR_NONE);
   localparam lut_type DEC_FIFTH = build_lut(MODE_DECODE, FACTOR_FIFTH);
   localparam lut_type DEC_HALF = build_lut(MODE_DECODE, FACTOR_HALF);
   localparam lut_type DEC_FOUR = build_lut(MODE_DECODE, FACTOR_FOUR_FIFTHS);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in_sel;

   // Pick the curve entry
   always_comb begin
      byte_in_sel = '0;
      case ({mode, factor})
         {MODE_ENCODE, FACTOR_NONE}:        byte_in_sel = ENC_NONE[byte_in];
         {MODE_ENCODE, FACTOR_FIFTH}:       byte_in_sel = ENC_FIFTH[byte_in];
         {MODE_ENCODE, FACTOR_HALF}:        byte_in_sel = ENC_HALF[byte_in];
         {MODE_ENCODE, FACTOR_FOUR_FIFTHS}: byte_in_sel = ENC_FOUR[byte_in];
         {MODE_DECODE, FACTOR_NONE}:        byte_in_sel = DEC_NONE[byte_in];
         {MODE_DECODE, FACTOR_FIFTH}:       byte_in_sel = DEC_FIFTH[byte_in];
         {MODE_DECODE, FACTOR_HALF}:        byte_in_sel = DEC_HALF[byte_in];
         {MODE_DECODE, FACTOR_FOUR_FIFTHS}: byte_in_sel = DEC_FOUR[byte_in];
         default:                           byte_in_sel = '0;
      endcase
   end

   // Hold while the stage is stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         byte_ff <= byte_in_sel;
      end
   end

   assign byte_out = byte_ff;

endmodule

// ===== rtl/pcot_merge.sv =====
// ----------------------------------------------------------------------------
// pcot_merge
// Combines the lane results with alpha and the marker into the output beat.
// ----------------------------------------------------------------------------
module pcot_merge
   import pcot_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [BYTE_W-1:0] red_lane,
   input  logic [BYTE_W-1:0] green_lane,
   input  logic [BYTE_W-1:0] blue_lane,
   input  side_type          side,
   output logic [BYTE_W-1:0] red_out,
   output logic [BYTE_W-1:0] green_out,
   output logic [BYTE_W-1:0] blue_out,
   output logic [BYTE_W-1:0] alpha_out,
   output logic              end_of_image_out
);

   logic [BYTE_W-1:0] red_ff;
   logic [BYTE_W-1:0] green_ff;
   logic [BYTE_W-1:0] blue_ff;
   logic [BYTE_W-1:0] alpha_ff;
   logic              eoi_ff;

   // Transparent encode pixels turn white
   always_ff @(posedge clock) begin
      if (enable) begin
         red_ff   <= side.force_white ? WHITE_BYTE : red_lane;
         green_ff <= side.force_white ? WHITE_BYTE : green_lane;
         blue_ff  <= side.force_white ? WHITE_BYTE : blue_lane;
         alpha_ff <= side.alpha;
         eoi_ff   <= side.end_of_image;
      end
   end

   assign red_out          = red_ff;
   assign green_out        = green_ff;
   assign blue_out         = blue_ff;
   assign alpha_out        = alpha_ff;
   assign end_of_image_out = eoi_ff;

endmodule

// ===== rtl/pixel_color_obfuscation_transform.sv =====
// Throughput: 1 pixel per cycle when not stalled; three channel lanes look up
// their curves in parallel from constant tables into the lane registers, then
// a merge register forms the beat. A stalled response holds the merge stage
// and a full lane stage; req_stall is raised only when both stages are full.
// Reset (synchronous, active high) empties the pipeline and sets mode to encode.
// ----------------------------------------------------------------------------
// pixel_color_obfuscation_transform
// Per-pixel reversible RGBA8 color transform, encode or decode by mode.
// ----------------------------------------------------------------------------
module pixel_color_obfuscation_transform
   import pcot_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_red_in,
   input  logic [BYTE_W-1:0] req_green_in,
   input  logic [BYTE_W-1:0] req_blue_in,
   input  logic [BYTE_W-1:0] req_alpha_in,
   input  logic              req_end_of_image,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_red_out,
   output logic [BYTE_W-1:0] rsp_green_out,
   output logic [BYTE_W-1:0] rsp_blue_out,
   output logic [BYTE_W-1:0] rsp_alpha_out,
   output logic              rsp_end_of_image_out
);

   mode_type          mode_ff;
   logic              lane_valid_ff;
   logic              out_valid_ff;
   side_type          side_ff;
   side_type          side_in;
   logic              lane_en;
   logic              out_en;
   factor_type        x_factor;
   factor_type        y_factor;
   logic [BYTE_W-1:0] red_lane;
   logic [BYTE_W-1:0] green_lane;
   logic [BYTE_W-1:0] blue_lane;

   // Advance each stage when the one after it can take the beat
   assign out_en    = !out_valid_ff || !rsp_stall;
   assign lane_en   = !lane_valid_ff || out_en;
   assign req_stall = !lane_en;

   // Blend factors from blue thresholds; decoded blue falls as the byte rises
   always_comb begin
      if (mode_ff == MODE_ENCODE) begin
         x_factor = (req_blue_in >= BLUE_QUARTER_BYTE) ? FACTOR_FOUR_FIFTHS : FACTOR_FIFTH;
         y_factor = (req_blue_in >= BLUE_THREE_QUARTERS_BYTE) ? FACTOR_HALF : FACTOR_FIFTH;
      end else begin
         x_factor = (req_blue_in <= BLUE_DEC_QUARTER_BYTE) ? FACTOR_FOUR_FIFTHS : FACTOR_FIFTH;
         y_factor = (req_blue_in <= BLUE_DEC_THREE_QUARTERS_BYTE) ? FACTOR_HALF : FACTOR_FIFTH;
      end
   end

   always_comb begin
      side_in.alpha        = req_alpha_in;
      side_in.end_of_image = req_end_of_image;
      side_in.force_white  = (mode_ff == MODE_ENCODE) && (req_alpha_in == '0);
   end

   // Mode register and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ENCODE;
         lane_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= mode_type'(csr_wdata);
         end
         if (lane_en) begin
            lane_valid_ff <= req_valid;
         end
         if (out_en) begin
            out_valid_ff <= lane_valid_ff;
         end
      end
   end

   // Hold sideband beside the lanes
   always_ff @(posedge clock) begin
      if (lane_en) begin
         side_ff <= side_in;
      end
   end

   pcot_lane u_lane_red (
      .clock    (clock),
      .enable   (lane_en),
      .mode     (mode_ff),
      .factor   (x_factor),
      .byte_in  (req_red_in),
      .byte_out (red_lane)
   );

   pcot_lane u_lane_green (
      .clock    (clock),
      .enable   (lane_en),
      .mode     (mode_ff),
      .factor   (y_factor),
      .byte_in  (req_green_in),
      .byte_out (green_lane)
   );

   pcot_lane u_lane_blue (
      .clock    (clock),
      .enable   (lane_en),
      .mode     (mode_ff),
      .factor   (FACTOR_NONE),
      .byte_in  (req_blue_in),
      .byte_out (blue_lane)
   );

   pcot_merge u_merge (
      .clock            (clock),
      .enable           (out_en),
      .red_lane         (red_lane),
      .green_lane       (green_lane),
      .blue_lane        (blue_lane),
      .side             (side_ff),
      .red_out          (rsp_red_out),
      .green_out        (rsp_green_out),
      .blue_out         (rsp_blue_out),
      .alpha_out        (rsp_alpha_out),
      .end_of_image_out (rsp_end_of_image_out)
   );

   assign rsp_valid = out_valid_ff;

endmodule

// ===== rtl/pcot_checker.sv =====
// ----------------------------------------------------------------------------
// pcot_checker
// Port-level checks on the pixel color transform, bound to the top level.
// ----------------------------------------------------------------------------
module pcot_checker
   import pcot_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              csr_we,
   input logic              csr_wdata,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_red_out,
   input logic [BYTE_W-1:0] rsp_green_out,
   input logic [BYTE_W-1:0] rsp_blue_out,
   input logic [BYTE_W-1:0] rsp_alpha_out
);

   logic mode_ff;

   // Track the mode seen on the register port
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // Pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Transparent pixels come out white in encode mode
   a_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mode_ff && rsp_alpha_out == '0 |->
      rsp_red_out == WHITE_BYTE && rsp_green_out == WHITE_BYTE &&
      rsp_blue_out == WHITE_BYTE)
      else $error("transparent pixel not white");

   // A response that appears stems from a request that was accepted and then passed the lane and merge registers
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_valid && !req_stall, 2))
      else $error("response without request");

endmodule

bind pixel_color_obfuscation_transform pcot_checker u_pcot_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_we        (csr_we),
   .csr_wdata     (csr_wdata),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_alpha_out (rsp_alpha_out)
);
